>>> sv/mecanum_wheel_odometry_macros.svh
// assertion macros for the odometry block
`ifndef MECANUM_WHEEL_ODOMETRY_MACROS_SVH
`define MECANUM_WHEEL_ODOMETRY_MACROS_SVH

// same-cycle implication
`define MWO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwo assertion failed");

// next-cycle implication
`define MWO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwo assertion failed");

`endif

>>> sv/mwo_pkg.sv
package mwo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_NEW_WEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_WEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN     = 3'd4;

  localparam logic [MUL_B_W-1:0] KINV_Q24 = 25'd10188014;

  typedef struct packed {
    logic [15:0] new_weight;
    logic [15:0] old_weight;
    logic [23:0] dist_per_count;
    logic [15:0] x_gain;
    logic [15:0] y_gain;
  } mwo_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FA, ST_FB, ST_FC, ST_SUM, ST_DX, ST_DY, ST_KX, ST_KY,
    ST_ROT, ST_QUAD, ST_CORD, ST_GX, ST_GY, ST_AY, ST_OUT
  } mwo_state_t;

  function automatic logic [29:0] atan_f(input logic [4:0] k);
    logic [29:0] v;
    unique case (k)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/mwo_cfg.sv
module mwo_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mwo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mwo_pkg::CFG_DAT_W-1:0] cfg_data,
  output mwo_pkg::mwo_cfg_t             cfg
);
  import mwo_pkg::*;

  mwo_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.new_weight     <= 16'd58982;
      cfg_r.old_weight     <= 16'd6554;
      cfg_r.dist_per_count <= 24'd45038;
      cfg_r.x_gain         <= 16'd16384;
      cfg_r.y_gain         <= 16'd16384;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NEW_WEIGHT: cfg_r.new_weight     <= cfg_data[15:0];
        CFG_OLD_WEIGHT: cfg_r.old_weight     <= cfg_data[15:0];
        CFG_DIST:       cfg_r.dist_per_count <= cfg_data;
        CFG_X_GAIN:     cfg_r.x_gain         <= cfg_data[15:0];
        CFG_Y_GAIN:     cfg_r.y_gain         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end
endmodule

>>> sv/mwo_mul.sv
module mwo_mul (
  input  logic                               clk,
  input  logic signed [mwo_pkg::MUL_A_W-1:0] mul_a,
  input  logic signed [mwo_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [mwo_pkg::MUL_P_W-1:0] prod_r
);
  import mwo_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end
endmodule

>>> sv/mecanum_wheel_odometry.sv
// Mecanum wheel odometry.
// in_*: one transfer per control period, in_tdata from bit 0 up holds
//   front_left_count, front_right_count, back_left_count, back_right_count, heading.
// out_*: one result per input, out_tdata from bit 0 up holds the four filtered wheel
//   speeds (24 bit each) and then x_position and y_position (48 bit each).
// cfg_*: register writes, always ready; index 0..4 selects the register.
// The block takes the next input in the cycle after the result is loaded
// into the output register. Time per item is set by the single shared
// multiplier (filter, scaling and gain products issued in turn) and by the
// CORDIC loop, one micro-rotation a cycle.
// in_tready is high only while the sequencer is idle.
// If the receiver stalls, the result is held in the output register; a new
// item can be accepted meanwhile but its result waits until that one leaves.
// Reset clears filter state, position accumulators and the output valid and
// reloads the register defaults.
module mecanum_wheel_odometry #(
  parameter int CORDIC_STEPS = mwo_pkg::CORDIC_STEPS_DEF,
  parameter int COUNT_BITS   = mwo_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fl_count, fr_count, bl_count, br_count, heading
  input  logic [79:0]                   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // fl_speed, fr_speed, bl_speed, br_speed, x_position, y_position
  output logic [191:0]                  out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mwo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mwo_pkg::CFG_DAT_W-1:0] cfg_data
);
  import mwo_pkg::*;

  localparam int SW  = $clog2(CORDIC_STEPS);
  localparam int CSH = 32 - COUNT_BITS;

  mwo_cfg_t cfg;
  mwo_state_t state_r, state_nxt;

  logic signed [33:0] raw_r [4];
  logic [15:0]        head_r;
  logic signed [23:0] filt_r [4];
  logic [1:0]         wheel_r;
  logic [SW-1:0]      step_r;
  logic signed [MUL_P_W:0] acc_r;
  logic signed [MUL_A_W-1:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic signed [47:0] ax_r, ay_r;
  logic [191:0]       out_r;
  logic               out_valid_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_r;

  mwo_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  mwo_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .prod_r(prod_r));

  function automatic logic signed [33:0] sext_cnt(input logic [15:0] f);
    logic signed [31:0] v;
    v = signed'(32'(f) << CSH);
    return 34'(v >>> CSH);
  endfunction

  function automatic logic signed [MUL_A_W-1:0] rnd_p(input logic signed [MUL_P_W-1:0] p,
                                                      input int s);
    logic signed [MUL_P_W-1:0] t;
    t = (p + (MUL_P_W'(1) << (s - 1))) >>> s;
    return t[MUL_A_W-1:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v > 49'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -49'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  logic signed [MUL_P_W:0] filt_sum;
  logic signed [MUL_P_W:0] filt_rnd;
  logic signed [23:0]      filt_new;
  logic signed [25:0]      bsum, bdif;
  logic signed [MUL_A_W-1:0] xs, ys;
  logic signed [33:0]      atan_v;
  logic signed [48:0]      acc_add;
  logic signed [31:0]      ang;
  logic                    load_out;

  always_comb begin
    filt_sum = acc_r + (MUL_P_W + 1)'(prod_r) + (MUL_P_W + 1)'(32768);
    filt_rnd = filt_sum >>> 16;
    if (filt_rnd > (MUL_P_W + 1)'(8388607)) filt_new = 24'sh7FFFFF;
    else if (filt_rnd < -(MUL_P_W + 1)'(8388608)) filt_new = 24'sh800000;
    else filt_new = filt_rnd[23:0];
    bsum = 26'(filt_r[0]) + 26'(filt_r[1]) + 26'(filt_r[2]) + 26'(filt_r[3]);
    bdif = 26'(filt_r[0]) - 26'(filt_r[1]) - 26'(filt_r[2]) + 26'(filt_r[3]);
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    atan_v = 34'(atan_f(5'(step_r)));
    acc_add = (state_r == ST_GY) ? 49'(ax_r) + 49'(rnd_p(prod_r, 18))
                                 : 49'(ay_r) + 49'(rnd_p(prod_r, 18));
    ang = signed'(32'd0 - {head_r, 16'd0});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_FA: begin
        mul_a = MUL_A_W'(raw_r[wheel_r]);
        mul_b = MUL_B_W'({1'b0, cfg.new_weight});
      end
      ST_FB: begin
        mul_a = MUL_A_W'(filt_r[wheel_r]);
        mul_b = MUL_B_W'({1'b0, cfg.old_weight});
      end
      ST_DX: begin
        mul_a = x_r;
        mul_b = MUL_B_W'({1'b0, cfg.dist_per_count});
      end
      ST_DY: begin
        mul_a = y_r;
        mul_b = MUL_B_W'({1'b0, cfg.dist_per_count});
      end
      ST_KX: begin
        mul_a = x_r;
        mul_b = KINV_Q24;
      end
      ST_KY: begin
        mul_a = y_r;
        mul_b = KINV_Q24;
      end
      ST_GX: begin
        mul_a = x_r;
        mul_b = MUL_B_W'({1'b0, cfg.x_gain});
      end
      ST_GY: begin
        mul_a = y_r;
        mul_b = MUL_B_W'({1'b0, cfg.y_gain});
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_FA;
      ST_FA:   state_nxt = ST_FB;
      ST_FB:   state_nxt = ST_FC;
      ST_FC:   state_nxt = (wheel_r == 2'd3) ? ST_SUM : ST_FA;
      ST_SUM:  state_nxt = ST_DX;
      ST_DX:   state_nxt = ST_DY;
      ST_DY:   state_nxt = ST_KX;
      ST_KX:   state_nxt = ST_KY;
      ST_KY:   state_nxt = ST_ROT;
      ST_ROT:  state_nxt = ST_QUAD;
      ST_QUAD: state_nxt = ST_CORD;
      ST_CORD: if (step_r == SW'(CORDIC_STEPS - 1)) state_nxt = ST_GX;
      ST_GX:   state_nxt = ST_GY;
      ST_GY:   state_nxt = ST_AY;
      ST_AY:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wheel_r     <= '0;
      step_r      <= '0;
      ax_r        <= '0;
      ay_r        <= '0;
      for (int i = 0; i < 4; i++) filt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          wheel_r <= '0;
          step_r  <= '0;
          if (in_tvalid) begin
            raw_r[0] <= sext_cnt(in_tdata[15:0]);
            raw_r[1] <= -sext_cnt(in_tdata[31:16]);
            raw_r[2] <= sext_cnt(in_tdata[47:32]);
            raw_r[3] <= -sext_cnt(in_tdata[63:48]);
            head_r   <= in_tdata[79:64];
          end
        end
        ST_FB: acc_r <= (MUL_P_W + 1)'(prod_r) <<< 8;
        ST_FC: begin
          filt_r[wheel_r] <= filt_new;
          wheel_r <= wheel_r + 2'd1;
        end
        ST_SUM: begin
          x_r <= MUL_A_W'(bsum);
          y_r <= MUL_A_W'(bdif);
        end
        ST_DY: x_r <= rnd_p(prod_r, 14);
        ST_KX: y_r <= rnd_p(prod_r, 14);
        ST_KY: x_r <= rnd_p(prod_r, 24);
        ST_ROT: begin
          y_r <= rnd_p(prod_r, 24);
          z_r <= 34'(ang);
        end
        ST_QUAD: begin
          if (z_r > 34'sd1073741824 || z_r < -34'sd1073741824) begin
            x_r <= -x_r;
            y_r <= -y_r;
            z_r <= 34'(signed'(z_r[31:0] ^ 32'h8000_0000));
          end
        end
        ST_CORD: begin
          if (!z_r[33]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_v;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_v;
          end
          step_r <= step_r + SW'(1);
        end
        ST_GY: ax_r <= sat48(acc_add);
        ST_AY: ay_r <= sat48(acc_add);
        ST_OUT: begin
          if (load_out)
            out_r <= {ay_r, ax_r, filt_r[3], filt_r[2], filt_r[1], filt_r[0]};
        end
        default: ;
      endcase
    end
  end

`include "mecanum_wheel_odometry_macros.svh"

  `MWO_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `MWO_ASSERT_NEXT(a_hold_when_stalled, state_r == ST_OUT && out_valid_r && !out_tready, state_r == ST_OUT)
  `MWO_ASSERT_NOW(a_step_in_range, state_r == ST_CORD, step_r <= SW'(CORDIC_STEPS - 1))
  `MWO_ASSERT_NEXT(a_result_after_out, load_out, out_tvalid && in_tready)

endmodule

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mwo_pkg::*;

  localparam int CORDIC_N = 16;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] br;
    logic signed [15:0] bl;
    logic signed [15:0] fr;
    logic signed [15:0] fl;
  } wheel_item_t;

  typedef struct packed {
    logic signed [47:0] y_pos;
    logic signed [47:0] x_pos;
    logic signed [23:0] br;
    logic signed [23:0] bl;
    logic signed [23:0] fr;
    logic signed [23:0] fl;
  } odo_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mecanum_wheel_odometry u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  longint new_w, old_w, dist_cnt, gain_x, gain_y;
  longint wheel_filt [4];
  longint pos_x, pos_y;

  wheel_item_t pending_items[$];
  odo_result_t expected_odo[$];
  int errors = 0;
  int hold_cycles = 0;
  bit mode_burst = 0;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint turn_atan(int k);
    longint t [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                       21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                       333772, 166886, 83443, 41722, 20861};
    return t[k];
  endfunction

  function automatic odo_result_t advance_odometry(wheel_item_t it);
    longint raw [4];
    longint acc, bx, by, x, y, z, nx, ny;
    logic [31:0] ang;
    odo_result_t r;
    raw[0] = it.fl;
    raw[1] = -longint'(it.fr);
    raw[2] = it.bl;
    raw[3] = -longint'(it.br);
    for (int i = 0; i < 4; i++) begin
      acc = new_w * raw[i] * 256 + old_w * wheel_filt[i];
      wheel_filt[i] = clip(round_sh(acc, 16), 24);
    end
    bx = wheel_filt[0] + wheel_filt[1] + wheel_filt[2] + wheel_filt[3];
    by = wheel_filt[0] - wheel_filt[1] - wheel_filt[2] + wheel_filt[3];
    bx = round_sh(bx * dist_cnt, 14);
    by = round_sh(by * dist_cnt, 14);
    x = round_sh(bx * longint'(KINV_Q24), 24);
    y = round_sh(by * longint'(KINV_Q24), 24);
    ang = 32'd0 - {it.heading, 16'h0};
    z = longint'(signed'(ang));
    if (z > (longint'(1) << 30) || z < -(longint'(1) << 30)) begin
      x = -x;
      y = -y;
      ang = ang + 32'h8000_0000;
      z = longint'(signed'(ang));
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= turn_atan(i);
      end else begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += turn_atan(i);
      end
      x = nx;
      y = ny;
    end
    pos_x = clip(pos_x + round_sh(x * gain_x, 18), 48);
    pos_y = clip(pos_y + round_sh(y * gain_y, 18), 48);
    r.fl = wheel_filt[0][23:0];
    r.fr = wheel_filt[1][23:0];
    r.bl = wheel_filt[2][23:0];
    r.br = wheel_filt[3][23:0];
    r.x_pos = pos_x[47:0];
    r.y_pos = pos_y[47:0];
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_odo.push_back(advance_odometry(wheel_item_t'(in_tdata)));
        tx_gap = mode_burst ? 0 : pick_gap();
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_items.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int rx_gap = 0;
  always @(posedge clk) begin
    odo_result_t got, exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = odo_result_t'(out_tdata);
        if (expected_odo.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          exp_r = expected_odo.pop_front();
          if (got.fl !== exp_r.fl) begin
            $error("front_left_speed exp %0d got %0d", exp_r.fl, got.fl); errors++;
          end
          if (got.fr !== exp_r.fr) begin
            $error("front_right_speed exp %0d got %0d", exp_r.fr, got.fr); errors++;
          end
          if (got.bl !== exp_r.bl) begin
            $error("back_left_speed exp %0d got %0d", exp_r.bl, got.bl); errors++;
          end
          if (got.br !== exp_r.br) begin
            $error("back_right_speed exp %0d got %0d", exp_r.br, got.br); errors++;
          end
          if (got.x_pos !== exp_r.x_pos) begin
            $error("x_position exp %0d got %0d", exp_r.x_pos, got.x_pos); errors++;
          end
          if (got.y_pos !== exp_r.y_pos) begin
            $error("y_position exp %0d got %0d", exp_r.y_pos, got.y_pos); errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!mode_burst) rx_gap = pick_gap();
      end
    end
  end

  // watchdog
  int idle_count = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_valid)
      idle_count <= 0;
    else if (pending_items.size() > 0 || expected_odo.size() > 0 || in_tvalid)
      idle_count <= idle_count + 1;
    if (idle_count > STALL_LIMIT) begin
      $display("mecanum_wheel_odometry test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_tvalid || expected_odo.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    longint m;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m = val & 64'hFFFF;
    case (idx)
      CFG_NEW_WEIGHT: new_w = m;
      CFG_OLD_WEIGHT: old_w = m;
      CFG_DIST:       dist_cnt = val & 64'hFFFFFF;
      CFG_X_GAIN:     gain_x = m;
      CFG_Y_GAIN:     gain_y = m;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 40)) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_item(int a, b, c, d, h);
    wheel_item_t it;
    it.fl = 16'(a); it.fr = 16'(b); it.bl = 16'(c); it.br = 16'(d); it.heading = 16'(h);
    pending_items.push_back(it);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_item(rand_count(), rand_count(), rand_count(), rand_count(), 16'($urandom));
  endtask

  initial begin
    new_w = 58982; old_w = 6554; dist_cnt = 45038; gain_x = 16384; gain_y = 16384;
    for (int i = 0; i < 4; i++) wheel_filt[i] = 0;
    pos_x = 0; pos_y = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, headings around the quadrant fold
    add_item(0, 0, 0, 0, 0);
    add_item(100, -100, 100, -100, 0);
    add_item(100, 100, 100, 100, 16384);
    add_item(100, -100, 100, -100, 16385);
    add_item(50, 20, -30, 7, -16384);
    add_item(50, 20, -30, 7, -16385);
    add_item(-1, 1, 1, -1, 16'sh8000);
    add_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    add_item(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 8192);
    add_item(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, -8192);
    wait_drained();

    // heavy filter feedback to hit saturation, with maximum scaling and gains
    write_reg(CFG_NEW_WEIGHT, 65535);
    write_reg(CFG_OLD_WEIGHT, 65535);
    write_reg(CFG_DIST, 24'hFFFFFF);
    write_reg(CFG_X_GAIN, 65535);
    write_reg(CFG_Y_GAIN, 65535);
    write_reg(CFG_UNUSED_IDX, 24'h123456);
    for (int i = 0; i < 12; i++) add_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 0);
    for (int i = 0; i < 12; i++)
      add_item(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    add_random(40);
    wait_drained();

    // zero weights and gains
    write_reg(CFG_NEW_WEIGHT, 0);
    write_reg(CFG_OLD_WEIGHT, 0);
    write_reg(CFG_DIST, 0);
    write_reg(CFG_X_GAIN, 0);
    write_reg(CFG_Y_GAIN, 0);
    add_random(20);
    wait_drained();

    // receiver holds off while the sender keeps offering
    write_reg(CFG_NEW_WEIGHT, 58982);
    write_reg(CFG_OLD_WEIGHT, 6554);
    write_reg(CFG_DIST, 45038);
    write_reg(CFG_X_GAIN, 16384);
    write_reg(CFG_Y_GAIN, 16384);
    mode_burst = 1;
    hold_cycles = 400;
    add_random(10);
    wait_drained();
    mode_burst = 0;

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_NEW_WEIGHT, $urandom_range(0, 65535));
      write_reg(CFG_OLD_WEIGHT, $urandom_range(0, 65535));
      write_reg(CFG_DIST, $urandom_range(0, 24'hFFFFFF));
      write_reg(CFG_X_GAIN, $urandom_range(0, 65535));
      write_reg(CFG_Y_GAIN, $urandom_range(0, 65535));
      add_random(130);
      wait_drained();
    end

    if (errors == 0) begin
      $display("mecanum_wheel_odometry test passed");
    end else begin
      $display("mecanum_wheel_odometry test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
